// File: rtl/qdec_pkg.sv
package qdec_pkg;

    localparam logic [1:0] CMD_CHAN_A = 2'd0;
    localparam logic [1:0] CMD_CHAN_B = 2'd1;
    localparam logic [1:0] CMD_INDEX  = 2'd2;

    localparam logic [1:0] LEVEL_LOW  = 2'd0;
    localparam logic [1:0] LEVEL_HIGH = 2'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_NOP  = 2'd0,
        OP_CHAN = 2'd1,
        OP_TURN = 2'd2
    } op_kind_t;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } step_t;

    typedef struct packed {
        op_kind_t    kind;
        logic        chan_b;
        logic        level;
        logic [31:0] tick;
    } op_t;

    function automatic step_t quad_step(input logic [3:0] idx);
        step_t step;
        case (idx)
            4'd2, 4'd4, 4'd11, 4'd13: step = STEP_UP;
            4'd1, 4'd7, 4'd8, 4'd14:  step = STEP_DOWN;
            default:                  step = STEP_NONE;
        endcase
        return step;
    endfunction

endpackage

// File: rtl/quadrature_decoder_sync_capture_unit.sv
// Quadrature x4 decoder with aligned capture. Each input beat is one edge event
// (channel A, channel B or index) with its timestamp, and each beat yields
// exactly one result beat showing the position, last event tick, the most
// recent position that was a multiple of four with its tick, and the index
// turn count. While the result side keeps m_ready high, the block sustains one
// beat per clock. An accepted input beat is first written into the two-entry
// queue between classification and update, and the update stage, which holds a
// single 64-bit increment or decrement of the position, then registers the
// result from the head of the queue. When the result side stalls, the queue
// absorbs up to two further beats before s_ready drops.
module quadrature_decoder_sync_capture_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [1:0]          s_pin_level,
    input  logic [31:0]         s_timestamp,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [63:0]  m_position,
    output logic [31:0]         m_last_event_tick,
    output logic signed [63:0]  m_aligned_position,
    output logic [31:0]         m_aligned_tick,
    output logic [62:0]         m_turns
);
    import qdec_pkg::*;

    logic front_valid, front_ready;
    op_t  front_op;
    logic back_valid, back_ready;
    op_t  back_op;

    qdec_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_pin_level (s_pin_level),
        .s_timestamp (s_timestamp),
        .op_valid    (front_valid),
        .op_ready    (front_ready),
        .op          (front_op)
    );

    qdec_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_op     (front_op),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_op    (back_op)
    );

    qdec_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .op_valid           (back_valid),
        .op_ready           (back_ready),
        .op                 (back_op),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_position         (m_position),
        .m_last_event_tick  (m_last_event_tick),
        .m_aligned_position (m_aligned_position),
        .m_aligned_tick     (m_aligned_tick),
        .m_turns            (m_turns)
    );

endmodule

// File: rtl/qdec_front.sv
module qdec_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [1:0]          s_pin_level,
    input  logic [31:0]         s_timestamp,
    output logic                op_valid,
    input  logic                op_ready,
    output qdec_pkg::op_t       op
);
    import qdec_pkg::*;

    op_kind_t kind;

    always_comb begin
        kind = OP_NOP;
        case (s_cmd)
            CMD_CHAN_A, CMD_CHAN_B: begin
                if (s_pin_level == LEVEL_LOW || s_pin_level == LEVEL_HIGH) begin
                    kind = OP_CHAN;
                end
            end
            CMD_INDEX: begin
                if (s_pin_level == LEVEL_HIGH) begin
                    kind = OP_TURN;
                end
            end
            default: begin
                kind = OP_NOP;
            end
        endcase
    end

    assign op.kind   = kind;
    assign op.chan_b = (s_cmd == CMD_CHAN_B);
    assign op.level  = s_pin_level[0];
    assign op.tick   = s_timestamp;

    assign op_valid = s_valid;
    assign s_ready  = op_ready;

endmodule

// File: rtl/qdec_queue.sv
module qdec_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  qdec_pkg::op_t  in_op,
    output logic           out_valid,
    input  logic           out_ready,
    output qdec_pkg::op_t  out_op
);
    import qdec_pkg::*;

    op_t                    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push, pop;

    assign in_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

// File: rtl/qdec_back.sv
module qdec_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                op_valid,
    output logic                op_ready,
    input  qdec_pkg::op_t       op,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [63:0]  m_position,
    output logic [31:0]         m_last_event_tick,
    output logic signed [63:0]  m_aligned_position,
    output logic [31:0]         m_aligned_tick,
    output logic [62:0]         m_turns
);
    import qdec_pkg::*;

    logic               level_a_reg, level_a_next;
    logic               level_b_reg, level_b_next;
    logic [3:0]         history_reg, history_next;
    logic [63:0]        position_reg, position_next;
    logic [31:0]        event_tick_reg, event_tick_next;
    logic [63:0]        aligned_reg, aligned_next;
    logic [31:0]        aligned_tick_reg, aligned_tick_next;
    logic [62:0]        turns_reg, turns_next;
    logic               out_valid_reg, out_valid_next;
    logic               pop;
    step_t              step;
    logic [63:0]        step_value;

    // The result register holds the state that the last beat produced, so no
    // new beat is taken until that result has left.
    assign op_ready = !out_valid_reg || m_ready;
    assign pop      = op_valid && op_ready;

    always_comb begin
        level_a_next      = level_a_reg;
        level_b_next      = level_b_reg;
        history_next      = history_reg;
        position_next     = position_reg;
        event_tick_next   = event_tick_reg;
        aligned_next      = aligned_reg;
        aligned_tick_next = aligned_tick_reg;
        turns_next        = turns_reg;
        if (op.chan_b) begin
            level_b_next = op.level;
        end else begin
            level_a_next = op.level;
        end
        step       = quad_step({history_reg[1:0], level_a_next, level_b_next});
        step_value = {{63{step == STEP_DOWN}}, step != STEP_NONE};
        if (pop) begin
            case (op.kind)
                OP_CHAN: begin
                    history_next    = {history_reg[1:0], level_a_next, level_b_next};
                    position_next   = position_reg + step_value;
                    event_tick_next = op.tick;
                    if (position_next[1:0] == 2'b00) begin
                        aligned_next      = position_next;
                        aligned_tick_next = op.tick;
                    end
                end
                OP_TURN: begin
                    turns_next = turns_reg + 63'd1;
                end
                default: begin
                end
            endcase
        end
        if (!pop || op.kind != OP_CHAN) begin
            level_a_next = level_a_reg;
            level_b_next = level_b_reg;
        end
        out_valid_next = pop ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_a_reg      <= 1'b1;
            level_b_reg      <= 1'b1;
            history_reg      <= '0;
            position_reg     <= '0;
            event_tick_reg   <= '0;
            aligned_reg      <= '0;
            aligned_tick_reg <= '0;
            turns_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            level_a_reg      <= level_a_next;
            level_b_reg      <= level_b_next;
            history_reg      <= history_next;
            position_reg     <= position_next;
            event_tick_reg   <= event_tick_next;
            aligned_reg      <= aligned_next;
            aligned_tick_reg <= aligned_tick_next;
            turns_reg        <= turns_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_position         = position_reg;
    assign m_last_event_tick  = event_tick_reg;
    assign m_aligned_position = aligned_reg;
    assign m_aligned_tick     = aligned_tick_reg;
    assign m_turns            = turns_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!out_valid_reg || m_ready))
        else $error("beat taken while a result was still waiting");

    a_tick_recorded: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && op.kind == OP_CHAN) |=> (event_tick_reg == $past(op.tick)))
        else $error("channel beat did not record its tick");

    a_aligned_multiple: assert property (@(posedge aclk) disable iff (!aresetn)
        aligned_reg[1:0] == 2'b00)
        else $error("aligned count is not a multiple of four");

    a_unit_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (position_reg == $past(position_reg)
               || position_reg == $past(position_reg) + 64'd1
               || position_reg == $past(position_reg) - 64'd1))
        else $error("position moved by more than one count");

    a_idle_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> ($stable(position_reg) && $stable(turns_reg) && $stable(history_reg)))
        else $error("state changed without a beat");

endmodule
